// ----- rtl/rqjd_pkg.sv -----
// Shared types, codes and constants for the ready queue job dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package rqjd_pkg;

  // Default sizes handed to the top level parameters
  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_TIME_WIDTH  = 16;

  // Fixed port field widths
  localparam int REQ_W      = 2;
  localparam int ID_W       = 8;
  localparam int EXT_TIME_W = 16;
  localparam int PRIO_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int QUANTUM_W  = 8;

  localparam logic [QUANTUM_W-1:0] RESET_QUANTUM = 8'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_SUBMIT   = 2'd0,
    REQ_DISPATCH = 2'd1,
    REQ_COMPLETE = 2'd2
  } req_kind_t;

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_SJF  = 2'd1,
    POL_RR   = 2'd2,
    POL_PRIO = 2'd3
  } policy_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_NO_RUN = 3'd3,
    ST_BUSY   = 3'd4
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic pick;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_needed;
    logic scan_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/rqjd_ifs.sv -----
// Request, result and configuration channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

interface rqjd_req_if import rqjd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [ID_W-1:0]       job_id;
  logic [EXT_TIME_W-1:0] job_time;
  logic [PRIO_W-1:0]     job_priority;

  modport source (output valid, req_type, job_id, job_time, job_priority, input ready);
  modport sink   (input valid, req_type, job_id, job_time, job_priority, output ready);
endinterface

interface rqjd_rsp_if import rqjd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [ID_W-1:0]       out_job_id;
  logic [EXT_TIME_W-1:0] slice;
  logic [EXT_TIME_W-1:0] remaining;
  logic                  finished;

  modport source (output valid, status, out_job_id, slice, remaining, finished, input ready);
  modport sink   (input valid, status, out_job_id, slice, remaining, finished, output ready);
endinterface

interface rqjd_cfg_if import rqjd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/rqjd_ram.sv -----
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module rqjd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/rqjd_ctrl.sv -----
// Sequencer for the dispatcher: request intake, scan and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module rqjd_ctrl import rqjd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_PICK = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  // Output register can take a new result this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Commands
  always_comb begin
    cmd.capture  = in_ready && in_valid;
    cmd.exec     = (state == S_EXEC) && out_free;
    cmd.scan     = (state == S_SCAN);
    cmd.pick     = (state == S_PICK) && out_free;
    cmd.load_out = (cmd.exec && !stat.scan_needed) || cmd.pick;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = stat.scan_needed ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_PICK;
      end
      S_PICK: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rqjd_dpath.sv -----
// Datapath: ready queue storage, pointers, running job, scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module rqjd_dpath import rqjd_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  input  wire logic [REQ_W-1:0]      req_type,
  input  wire logic [ID_W-1:0]       job_id,
  input  wire logic [EXT_TIME_W-1:0] job_time,
  input  wire logic [PRIO_W-1:0]     job_priority,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic [STATUS_W-1:0]        status,
  output logic [ID_W-1:0]            out_job_id,
  output logic [EXT_TIME_W-1:0]      slice,
  output logic [EXT_TIME_W-1:0]      remaining,
  output logic                       finished
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = ID_W + TIME_WIDTH + PRIO_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // Entry layout: {id, remaining time, priority}
  function automatic logic [ID_W-1:0] ent_id(input logic [ENT_W-1:0] e);
    return e[ENT_W-1 -: ID_W];
  endfunction

  function automatic logic [TIME_WIDTH-1:0] ent_rem(input logic [ENT_W-1:0] e);
    return e[PRIO_W +: TIME_WIDTH];
  endfunction

  function automatic logic [PRIO_W-1:0] ent_prio(input logic [ENT_W-1:0] e);
    return e[PRIO_W-1:0];
  endfunction

  function automatic logic [TIME_WIDTH-1:0] to_tw(input logic [EXT_TIME_W-1:0] v);
    logic [EXT_TIME_W+TIME_WIDTH-1:0] w;
    w = {{TIME_WIDTH{1'b0}}, v};
    return w[TIME_WIDTH-1:0];
  endfunction

  function automatic logic [EXT_TIME_W-1:0] to_ext(input logic [TIME_WIDTH-1:0] v);
    logic [EXT_TIME_W+TIME_WIDTH-1:0] w;
    w = {{EXT_TIME_W{1'b0}}, v};
    return w[EXT_TIME_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  // Configuration
  policy_t              policy;
  logic [QUANTUM_W-1:0] quantum;
  logic [TIME_WIDTH-1:0] quantum_tw;
  logic [QUANTUM_W+TIME_WIDTH-1:0] quantum_wide;

  // Captured request
  logic [REQ_W-1:0]      rq_type;
  logic [ID_W-1:0]       rq_id;
  logic [TIME_WIDTH-1:0] rq_time;
  logic [PRIO_W-1:0]     rq_prio;
  req_kind_t             kind;

  // Queue pointers and running job
  logic [IDX_W-1:0]      head;
  logic [IDX_W-1:0]      tail;
  logic [CNT_W-1:0]      count;
  logic                  full;
  logic [ENT_W-1:0]      run_ent;
  logic                  run_valid;
  logic [TIME_WIDTH-1:0] granted;

  // Scan state
  logic [IDX_W-1:0]      scan_ptr;
  logic [CNT_W-1:0]      iss_left;
  logic                  rvld;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  first;
  logic [ENT_W-1:0]      best_ent;
  logic [IDX_W-1:0]      best_idx;
  logic [ENT_W-1:0]      head_ent;
  policy_t               pol_q;
  logic                  better;

  // Memory port
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic [ENT_W-1:0]      ram_rdata;

  // Completion arithmetic and result
  logic [TIME_WIDTH-1:0] dec;
  logic [TIME_WIDTH-1:0] new_rem;
  logic [TIME_WIDTH-1:0] grant_pick;
  logic [TIME_WIDTH-1:0] best_rem;
  logic [TIME_WIDTH-1:0] head_rem;
  status_t               res_status;
  logic [ID_W-1:0]       res_id;
  logic [EXT_TIME_W-1:0] res_slice;
  logic [EXT_TIME_W-1:0] res_rem;
  logic                  res_fin;

  rqjd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_ptr),
    .rdata (ram_rdata)
  );

  assign kind         = req_kind_t'(rq_type);
  assign full         = (count >= FULL_CNT);
  assign quantum_wide = {{TIME_WIDTH{1'b0}}, quantum};
  assign quantum_tw   = quantum_wide[TIME_WIDTH-1:0];
  assign best_rem     = ent_rem(best_ent);
  assign head_rem     = ent_rem(head_ent);
  assign grant_pick   = (pol_q == POL_RR) ? quantum_tw : best_rem;

  // Slice accounting for the running job
  assign dec     = (ent_rem(run_ent) < granted) ? ent_rem(run_ent) : granted;
  assign new_rem = ent_rem(run_ent) - dec;

  // Scan compare: strict less keeps the earliest entry on ties
  assign better = (pol_q == POL_SJF) ? (ent_rem(ram_rdata) < best_rem)
                                     : (ent_prio(ram_rdata) < ent_prio(best_ent));

  always_comb begin
    stat.scan_needed = (kind == REQ_DISPATCH) && !run_valid && (count != '0);
    stat.scan_done   = (iss_left == '0) && !rvld;
  end

  // Result and queue write selection
  always_comb begin
    res_status = ST_OK;
    res_id     = '0;
    res_slice  = '0;
    res_rem    = '0;
    res_fin    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = tail;
    ram_wdata  = {rq_id, rq_time, rq_prio};
    if (cmd.pick) begin
      res_id    = ent_id(best_ent);
      res_slice = to_ext(grant_pick);
      res_rem   = to_ext(best_rem);
      // swap: the old head moves to the chosen slot, the head slot is popped
      ram_we    = 1'b1;
      ram_waddr = best_idx;
      ram_wdata = head_ent;
    end else begin
      case (kind)
        REQ_SUBMIT: begin
          res_id  = rq_id;
          res_rem = to_ext(rq_time);
          if (full) begin
            res_status = ST_FULL;
          end else begin
            ram_we = cmd.exec;
          end
        end
        REQ_DISPATCH: begin
          if (run_valid) begin
            res_status = ST_BUSY;
          end else if (count == '0) begin
            res_status = ST_EMPTY;
          end
        end
        REQ_COMPLETE: begin
          if (!run_valid) begin
            res_status = ST_NO_RUN;
          end else begin
            res_id    = ent_id(run_ent);
            res_slice = to_ext(granted);
            res_rem   = to_ext(new_rem);
            res_fin   = (new_rem == '0);
            ram_wdata = {ent_id(run_ent), new_rem, ent_prio(run_ent)};
            if ((new_rem != '0) && (policy == POL_RR)) begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ram_we = cmd.exec;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= POL_FCFS;
      quantum   <= RESET_QUANTUM;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      run_valid <= 1'b0;
      iss_left  <= '0;
      rvld      <= 1'b0;
      first     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLICY:  policy  <= policy_t'(cfg_data[1:0]);
          CFG_QUANTUM: quantum <= cfg_data[QUANTUM_W-1:0];
          default: ;
        endcase
      end

      // Queue push (submit or round robin requeue)
      if (cmd.exec && ram_we) begin
        tail  <= next_slot(tail);
        count <= count + CNT_W'(1);
      end

      if (cmd.exec) begin
        case (kind)
          REQ_DISPATCH: begin
            if (stat.scan_needed) begin
              iss_left <= ((policy == POL_SJF) || (policy == POL_PRIO)) ? count
                                                                        : CNT_W'(1);
              first    <= 1'b1;
            end
          end
          REQ_COMPLETE: begin
            if (run_valid) begin
              if ((new_rem == '0) || (policy != POL_RR) || !full) begin
                run_valid <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end

      // Issue reads, then compare the returning entries
      if (cmd.scan) begin
        rvld <= (iss_left != '0);
        if (iss_left != '0) begin
          iss_left <= iss_left - CNT_W'(1);
        end
        if (rvld) begin
          first <= 1'b0;
        end
      end

      if (cmd.pick) begin
        run_valid <= 1'b1;
        head      <= next_slot(head);
        count     <= count - CNT_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rq_type <= req_type;
      rq_id   <= job_id;
      rq_time <= to_tw(job_time);
      rq_prio <= job_priority;
    end

    if (cmd.exec && stat.scan_needed) begin
      scan_ptr <= head;
      pol_q    <= policy;
    end

    if (cmd.exec && (kind == REQ_COMPLETE) && run_valid) begin
      run_ent <= {ent_id(run_ent), new_rem, ent_prio(run_ent)};
    end

    if (cmd.scan) begin
      if (iss_left != '0) begin
        scan_ptr <= next_slot(scan_ptr);
        rd_idx_q <= scan_ptr;
      end
      if (rvld) begin
        if (first || better) begin
          best_ent <= ram_rdata;
          best_idx <= rd_idx_q;
        end
        if (first) begin
          head_ent <= ram_rdata;
        end
      end
    end

    if (cmd.pick) begin
      run_ent <= best_ent;
      granted <= grant_pick;
    end

    if (cmd.load_out) begin
      status     <= res_status;
      out_job_id <= res_id;
      slice      <= res_slice;
      remaining  <= res_rem;
      finished   <= res_fin;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count exceeds queue depth");

  a_pick_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.pick |=> run_valid)
    else $error("dispatch did not start a running job");

  a_sjf_min: assert property (@(posedge clk) disable iff (rst)
    cmd.pick && (pol_q == POL_SJF) |-> best_rem <= head_rem)
    else $error("shortest job pick is longer than head");

  a_prio_min: assert property (@(posedge clk) disable iff (rst)
    cmd.pick && (pol_q == POL_PRIO) |-> ent_prio(best_ent) <= ent_prio(head_ent))
    else $error("priority pick is less urgent than head");

endmodule

`default_nettype wire

// ----- rtl/ready_queue_job_dispatcher.sv -----
// Top level of the ready queue job dispatcher.
//
// Channels: req takes one request per handshake (submit, dispatch, or
// completion report of the running job's slice); rsp returns exactly one
// result per request, in order; cfg writes the policy (index 0) and the
// round robin quantum (index 1) and is always ready. Write cfg only while
// no request is in flight.
// Timing: a submit or completion is captured in the idle state and its result
// is loaded in the exec state once the output register is free. A FCFS or
// round robin dispatch reads the head entry from the queue RAM. An SJF or
// priority dispatch scans every queued entry through the RAM's single
// registered read port, one per cycle, and loads its result in the pick state.
// Results sit in an output register; the next request is taken while a
// result waits, and only its own result stalls until rsp is taken.
// Reset: queue empty, no job running, policy FCFS, quantum 3. Queue RAM
// contents are never read before written, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ready_queue_job_dispatcher import rqjd_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
  input wire logic   clk,
  input wire logic   rst,
  rqjd_req_if.sink   req,
  rqjd_rsp_if.source rsp,
  rqjd_cfg_if.sink   cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  rqjd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  rqjd_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req.req_type),
    .job_id       (req.job_id),
    .job_time     (req.job_time),
    .job_priority (req.job_priority),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .status       (rsp.status),
    .out_job_id   (rsp.out_job_id),
    .slice        (rsp.slice),
    .remaining    (rsp.remaining),
    .finished     (rsp.finished)
  );

endmodule

`default_nettype wire
